>>> rtl/core/qte_pkg.sv
// Shared constants, types and functions of the quaternion to Euler angle converter.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int ANGLE_W       = 40;
  localparam int SCALED_W      = 55;

  localparam logic [14:0]              ANGLE_SCALE    = 15'd10430;
  localparam logic signed [ANGLE_W-1:0] PI_Q32        = 40'sd13493037704;
  localparam logic [63:0]              QUARTER_PI_Q32 = 64'd3373259426;
  localparam logic signed [63:0]       PITCH_LIMIT    = 64'sh0400_0000_0000_0000;
  localparam logic [62:0]              ONE_Q62        = 63'h4000_0000_0000_0000;
  localparam logic [5:0]               NORM_MSB       = 6'd59;

  typedef struct packed {
    logic signed [63:0] roll_y;
    logic signed [63:0] roll_x;
    logic signed [63:0] yaw_y;
    logic signed [63:0] yaw_x;
    logic               pitch_neg;
    logic [31:0]        pitch_mag;
  } side_t;

  function automatic logic signed [63:0] half_trunc(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + $signed({63'b0, v[63]});
    return t >>> 1;
  endfunction

  function automatic logic signed [63:0] quarter_trunc(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + $signed({62'b0, v[63], v[63]});
    return t >>> 2;
  endfunction

  function automatic logic [ANGLE_W-1:0] atan_q32(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          sh;
    sum = 64'd0;
    if (i == 0) begin
      return QUARTER_PI_Q32[ANGLE_W-1:0];
    end
    for (int k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 60) begin
        term = (64'd1 << (60 - sh)) / 64'(2 * k + 1);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    sum = (sum + (64'd1 << 27)) >> 28;
    return sum[ANGLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/qte_if.sv
// Channel interfaces: quaternion input and Euler angle output.
`default_nettype none
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface
`default_nettype wire

>>> rtl/core/qte_front.sv
// Product, sum and pitch argument stages ahead of the square root.
`default_nettype none
module qte_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] w,
  input  wire logic signed [31:0] x,
  input  wire logic signed [31:0] y,
  input  wire logic signed [31:0] z,
  output logic                    out_valid,
  output logic [63:0]             sq,
  output qte_pkg::side_t          side
);

  logic v1, v2, v3, v4;
  logic signed [63:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic signed [63:0] ww4, xx4, yy4, zz4, wx2, wy2, wz2, xy2, xz2, yz2;
  logic signed [63:0] roll_y, roll_x, yaw_y, yaw_x, d;
  qte_pkg::side_t     s4;
  logic signed [63:0] dc;
  logic signed [63:0] dmag;

  always_comb begin
    if (d > qte_pkg::PITCH_LIMIT) begin
      dc = qte_pkg::PITCH_LIMIT;
    end else if (d < -qte_pkg::PITCH_LIMIT) begin
      dc = -qte_pkg::PITCH_LIMIT;
    end else begin
      dc = d;
    end
    dmag = dc[63] ? -dc : dc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= w * w;
      xx <= x * x;
      yy <= y * y;
      zz <= z * z;
      wx <= w * x;
      wy <= w * y;
      wz <= w * z;
      xy <= x * y;
      xz <= x * z;
      yz <= y * z;

      ww4 <= qte_pkg::quarter_trunc(ww);
      xx4 <= qte_pkg::quarter_trunc(xx);
      yy4 <= qte_pkg::quarter_trunc(yy);
      zz4 <= qte_pkg::quarter_trunc(zz);
      wx2 <= qte_pkg::half_trunc(wx);
      wy2 <= qte_pkg::half_trunc(wy);
      wz2 <= qte_pkg::half_trunc(wz);
      xy2 <= qte_pkg::half_trunc(xy);
      xz2 <= qte_pkg::half_trunc(xz);
      yz2 <= qte_pkg::half_trunc(yz);

      roll_y <= yz2 + wx2;
      roll_x <= ww4 - xx4 - yy4 + zz4;
      yaw_y  <= xy2 + wz2;
      yaw_x  <= ww4 + xx4 - yy4 - zz4;
      d      <= xz2 - wy2;

      s4.roll_y    <= roll_y;
      s4.roll_x    <= roll_x;
      s4.yaw_y     <= yaw_y;
      s4.yaw_x     <= yaw_x;
      s4.pitch_neg <= d[63];
      s4.pitch_mag <= dmag[58:27];

      sq   <= 64'(s4.pitch_mag) * 64'(s4.pitch_mag);
      side <= s4;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/qte_isqrt.sv
// Pipelined floor square root of one minus the squared pitch argument.
`default_nettype none
module qte_isqrt (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [63:0]    sq,
  input  wire qte_pkg::side_t side_in,
  output logic                out_valid,
  output logic [31:0]         root,
  output qte_pkg::side_t      side_out
);

  localparam int N = qte_pkg::SQRT_STEPS;

  logic           v   [0:N];
  logic [62:0]    rem [0:N];
  logic [63:0]    acc [0:N];
  qte_pkg::side_t sd  [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= qte_pkg::ONE_Q62 - sq[62:0];
      acc[0] <= 64'd0;
      sd[0]  <= side_in;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] trial;
    assign trial = acc[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1] <= sd[s];
        if ({1'b0, rem[s]} >= trial) begin
          rem[s+1] <= rem[s] - trial[62:0];
          acc[s+1] <= (acc[s] >> 1) + BIT;
        end else begin
          rem[s+1] <= rem[s];
          acc[s+1] <= acc[s] >> 1;
        end
      end
    end
  end

  assign out_valid = v[N];
  assign root      = acc[N][31:0];
  assign side_out  = sd[N];

endmodule
`default_nettype wire

>>> rtl/core/qte_cordic.sv
// Pipelined atan2: normalise, vectoring CORDIC, quadrant fix and output scaling.
`default_nettype none
module qte_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [63:0] y_in,
  input  wire logic signed [63:0] x_in,
  output logic                    out_valid,
  output logic signed [15:0]      angle
);

  localparam int S  = qte_pkg::CORDIC_STAGES;
  localparam int AW = qte_pkg::ANGLE_W;

  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
  } flags_t;

  logic        n1_v, n2_v, n3_v;
  logic [63:0] n1_ax, n1_ay, n1_m, n2_ax, n2_ay, n2_m, n3_ax, n3_ay;
  logic [2:0]  n2_grp;
  logic [5:0]  n3_pos;
  flags_t      n1_f, n2_f, n3_f;

  logic signed [63:0]   cx [0:S];
  logic signed [63:0]   cy [0:S];
  logic signed [AW-1:0] cz [0:S];
  logic                 cv [0:S];
  flags_t               cf [0:S];

  logic                             q_v, m_v;
  logic signed [AW-1:0]             q_a;
  logic signed [qte_pkg::SCALED_W-1:0] m_p;

  logic [63:0] mag_x, mag_y;
  logic [2:0]  grp;
  logic [7:0]  byte_sel;
  logic [2:0]  bit_pos;
  logic [5:0]  pos;
  logic [5:0]  rsh, lsh;
  logic signed [AW-1:0] fixed_a;
  logic signed [qte_pkg::SCALED_W-1:0] rounded;
  logic signed [22:0] quot;
  logic signed [15:0] sat;

  always_comb begin
    mag_x = x_in[63] ? 64'(-x_in) : 64'(x_in);
    mag_y = y_in[63] ? 64'(-y_in) : 64'(y_in);
    grp     = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (n1_m[g*8 +: 8] != 8'd0) begin
        grp     = 3'(g);
      end
    end
    byte_sel = n2_m[{n2_grp, 3'b000} +: 8];
    bit_pos  = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte_sel[b]) begin
        bit_pos = 3'(b);
      end
    end
    pos = {n2_grp, bit_pos};
    rsh = n3_pos - qte_pkg::NORM_MSB;
    lsh = qte_pkg::NORM_MSB - n3_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
      n3_v <= 1'b0;
      cv[0] <= 1'b0;
    end else if (en) begin
      n1_v <= in_valid;
      n2_v <= n1_v;
      n3_v <= n2_v;
      cv[0] <= n3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_ax     <= mag_x;
      n1_ay     <= mag_y;
      n1_m      <= mag_x | mag_y;
      n1_f.zero <= (x_in == 64'sd0) && (y_in == 64'sd0);
      n1_f.xneg <= x_in[63];
      n1_f.yneg <= y_in[63];

      n2_ax     <= n1_ax;
      n2_ay     <= n1_ay;
      n2_m      <= n1_m;
      n2_grp    <= grp;
      n2_f      <= n1_f;

      n3_ax  <= n2_ax;
      n3_ay  <= n2_ay;
      n3_pos <= pos;
      n3_f   <= n2_f;

      if (n3_pos > qte_pkg::NORM_MSB) begin
        cx[0] <= $signed(n3_ax >> rsh);
        cy[0] <= $signed(n3_ay >> rsh);
      end else begin
        cx[0] <= $signed(n3_ax << lsh);
        cy[0] <= $signed(n3_ay << lsh);
      end
      cz[0] <= '0;
      cf[0] <= n3_f;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = $signed(qte_pkg::atan_q32(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cf[i+1] <= cf[i];
        if (!cy[i][63]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end
      end
    end
  end

  always_comb begin
    fixed_a = cf[S].zero ? '0 : cz[S];
    if (cf[S].xneg) begin
      fixed_a = qte_pkg::PI_Q32 - fixed_a;
    end
    if (cf[S].yneg) begin
      fixed_a = -fixed_a;
    end
    rounded = m_p[qte_pkg::SCALED_W-1] ? m_p + 55'sh0_FFFF_FFFF : m_p;
    quot    = 23'(rounded >>> 32);
    if (quot > 23'sd32767) begin
      sat = 16'sd32767;
    end else if (quot < -23'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
      m_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      q_v <= cv[S];
      m_v <= q_v;
      out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_a   <= fixed_a;
      m_p   <= q_a * $signed({1'b0, qte_pkg::ANGLE_SCALE});
      angle <= sat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/quaternion_to_euler_angles.sv
// Top level: quaternion in, roll, pitch and yaw out.
//
//  channel | direction | payload                                | interface
//  quat    | in        | quat_w, quat_x, quat_y, quat_z (Q2.30) | qte_quat_if.sink
//  euler   | out       | roll_angle, pitch_angle, yaw_angle     | qte_euler_if.source
//
// One transfer per cycle in and out while the output is not held; every lane runs through
// the front stages, the 32-step root pipeline and a CORDIC of CORDIC_STAGES stages.
// Synchronous reset empties every stage; no state survives between items.
// A held output stalls all stages together, and quat.ready falls with it.
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic          clk,
  input  wire logic          rst,
  qte_quat_if.sink           quat,
  qte_euler_if.source        euler
);

  logic           en;
  logic           f_v, r_v;
  logic [63:0]    f_sq;
  qte_pkg::side_t f_side, r_side;
  logic [31:0]    root;
  logic           roll_v, pitch_v, yaw_v;
  logic signed [63:0] pitch_y;

  assign en         = !euler.valid || euler.ready;
  assign quat.ready = en;
  assign euler.valid = roll_v && pitch_v && yaw_v;
  assign pitch_y    = r_side.pitch_neg ? -$signed(64'(r_side.pitch_mag))
                                       : $signed(64'(r_side.pitch_mag));

  qte_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(quat.valid),
    .w(quat.quat_w), .x(quat.quat_x), .y(quat.quat_y), .z(quat.quat_z),
    .out_valid(f_v), .sq(f_sq), .side(f_side)
  );

  qte_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_v), .sq(f_sq), .side_in(f_side),
    .out_valid(r_v), .root(root), .side_out(r_side)
  );

  qte_cordic u_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_v),
    .y_in(r_side.roll_y), .x_in(r_side.roll_x),
    .out_valid(roll_v), .angle(euler.roll_angle)
  );

  qte_cordic u_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_v),
    .y_in(pitch_y), .x_in($signed(64'(root))),
    .out_valid(pitch_v), .angle(euler.pitch_angle)
  );

  qte_cordic u_yaw (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_v),
    .y_in(r_side.yaw_y), .x_in(r_side.yaw_x),
    .out_valid(yaw_v), .angle(euler.yaw_angle)
  );

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (roll_v == pitch_v) && (pitch_v == yaw_v))
    else $error("angle lanes out of step");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    r_v |-> (root <= 32'h8000_0000))
    else $error("pitch root out of range");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (euler.valid && !euler.ready) |-> !quat.ready)
    else $error("input taken during output stall");

endmodule
`default_nettype wire
